FILE: sv/stc_pkg.sv
// Shared types, constants and character mapping functions for the six-bit text codec.
package stc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [5:0] SEXTET_SPLIT = 6'd34;
    localparam logic [7:0] LOW_OFFSET   = 8'h3E;
    localparam logic [7:0] HIGH_OFFSET  = 8'h3F;
    localparam logic [7:0] LOW_FIRST    = 8'h3E;
    localparam logic [7:0] LOW_END      = 8'h60;
    localparam logic [7:0] HIGH_END     = 8'h7F;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [1:0] {
        JOB_ENC,
        JOB_DEC,
        JOB_ERR
    } job_kind_t;

    // One unit of work for the back end: a group (an encode group may end a message short) or an error marker.
    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] bits;
        logic        last;
    } job_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] sextet;
    } sextet_t;

    localparam logic [1:0] ENC_FINAL_IDX = 2'd3;
    localparam logic [1:0] DEC_FINAL_IDX = 2'd2;
    localparam logic [1:0] ERR_FINAL_IDX = 2'd0;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
        logic [7:0] wide;
        wide = {2'b00, s};
        return (s < SEXTET_SPLIT) ? wide + LOW_OFFSET : wide + HIGH_OFFSET;
    endfunction

    function automatic sextet_t char_to_sextet(input logic [7:0] c);
        sextet_t r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= LOW_FIRST && c < LOW_END) begin
            d = c - LOW_OFFSET;
            r.ok = 1'b1;
        end else if (c > LOW_END && c < HIGH_END) begin
            d = c - HIGH_OFFSET;
            r.ok = 1'b1;
        end
        r.sextet = d[5:0];
        return r;
    endfunction

endpackage

FILE: sv/stc_channels.sv
// Handshake channel interfaces for the input, result and configuration ports.
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       error;
    modport source (output valid, output out_byte, output out_last, output error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input error,
                    output ready);
endinterface

interface stc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/stc_front.sv
// Front end: accepts items, gathers groups, checks characters and issues jobs.
module stc_front (
    input  logic         clk,
    input  logic         rst_n,
    stc_in_if.sink       in_ch,
    stc_cfg_if.sink      cfg,
    output logic         job_valid,
    output stc_pkg::job_t job,
    input  logic         job_ready
);
    import stc_pkg::*;

    logic        mode_reg,  mode_next;
    logic [23:0] bits_reg,  bits_next;
    logic [1:0]  count_reg, count_next;
    logic        bad_reg,   bad_next;

    logic        accept;
    logic        cfg_we;
    logic [2:0]  cnt;
    logic [23:0] enc_bits;
    logic [23:0] dec_bits;
    sextet_t     sx;
    logic        bad_now;
    logic        dec_full;

    assign cfg.ready   = 1'b1;
    assign cfg_we      = cfg.valid && cfg.ready;
    assign in_ch.ready = job_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign cnt      = {1'b0, count_reg} + 3'd1;
    assign enc_bits = {bits_reg[15:0], in_ch.in_byte};
    assign sx       = char_to_sextet(in_ch.in_byte);
    assign dec_bits = {bits_reg[17:0], sx.sextet};
    assign bad_now  = bad_reg || !sx.ok;
    assign dec_full = (cnt == 3'd4);

    always_comb
    begin
        mode_next  = mode_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        job_valid  = 1'b0;
        job        = '0;
        job.last   = in_ch.in_last;
        if (cfg_we) begin
            mode_next  = cfg.data;
            bits_next  = '0;
            count_next = '0;
            bad_next   = 1'b0;
        end else if (accept) begin
            if (mode_reg == MODE_ENCODE) begin
                job.kind = JOB_ENC;
                case (cnt)
                    3'd1:    job.bits = {enc_bits[7:0], 16'h0000};
                    3'd2:    job.bits = {enc_bits[15:0], 8'h00};
                    default: job.bits = enc_bits;
                endcase
                if (cnt == 3'd3 || in_ch.in_last) begin
                    job_valid  = 1'b1;
                    bits_next  = '0;
                    count_next = '0;
                end else begin
                    bits_next  = enc_bits;
                    count_next = cnt[1:0];
                end
                bad_next = 1'b0;
            end else begin
                job.bits = dec_bits;
                if (dec_full && !bad_now) begin
                    job.kind  = JOB_DEC;
                    job_valid = 1'b1;
                end else if (in_ch.in_last) begin
                    // Either a bad character or a short group at the end.
                    job.kind  = JOB_ERR;
                    job_valid = 1'b1;
                end
                if (in_ch.in_last) begin
                    bits_next  = '0;
                    count_next = '0;
                    bad_next   = 1'b0;
                end else begin
                    bits_next  = dec_full ? 24'h000000 : dec_bits;
                    count_next = cnt[1:0];
                    bad_next   = bad_now;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_ENCODE;
            bits_reg  <= '0;
            count_reg <= '0;
            bad_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            bits_reg  <= bits_next;
            count_reg <= count_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

FILE: sv/stc_queue.sv
// Short job queue between the front and back ends.
module stc_queue #(
    parameter int unsigned DEPTH = stc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  stc_pkg::job_t push_job,
    output logic          push_ready,
    output logic          pop_valid,
    output stc_pkg::job_t pop_job,
    input  logic          pop_ready
);
    import stc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             push;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        rd_ptr_next = pop  ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/stc_back.sv
// Back end: expands each job into its result items through an output register.
module stc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  stc_pkg::job_t job,
    output logic          job_pop,
    stc_out_if.source     out_ch
);
    import stc_pkg::*;

    job_t       cur_reg,   cur_next;
    logic [1:0] idx_reg,   idx_next;
    logic       busy_reg,  busy_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg,  byte_next;
    logic       last_reg,  last_next;
    logic       err_reg,   err_next;

    logic       load_out;
    logic       emit;
    logic       final_item;
    logic [1:0] final_idx;

    always_comb
    begin
        case (cur_reg.kind)
            JOB_ENC: final_idx = ENC_FINAL_IDX;
            JOB_DEC: final_idx = DEC_FINAL_IDX;
            default: final_idx = ERR_FINAL_IDX;
        endcase
    end

    assign load_out   = !valid_reg || out_ch.ready;
    assign emit       = busy_reg && load_out;
    assign final_item = (idx_reg == final_idx);
    assign job_pop    = job_valid && (!busy_reg || (emit && final_item));

    // Result payload for the current position in the job.
    always_comb
    begin
        byte_next = byte_reg;
        last_next = last_reg;
        err_next  = err_reg;
        if (emit) begin
            last_next = final_item && cur_reg.last;
            err_next  = 1'b0;
            case (cur_reg.kind)
                JOB_ENC:
                begin
                    case (idx_reg)
                        2'd0:    byte_next = sextet_to_char(cur_reg.bits[23:18]);
                        2'd1:    byte_next = sextet_to_char(cur_reg.bits[17:12]);
                        2'd2:    byte_next = sextet_to_char(cur_reg.bits[11:6]);
                        default: byte_next = sextet_to_char(cur_reg.bits[5:0]);
                    endcase
                end
                JOB_DEC:
                begin
                    case (idx_reg)
                        2'd0:    byte_next = cur_reg.bits[23:16];
                        2'd1:    byte_next = cur_reg.bits[15:8];
                        default: byte_next = cur_reg.bits[7:0];
                    endcase
                end
                default:
                begin
                    byte_next = 8'h00;
                    last_next = 1'b1;
                    err_next  = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cur_next   = job_pop ? job : cur_reg;
        idx_next   = job_pop ? 2'd0 : (emit ? idx_reg + 2'd1 : idx_reg);
        busy_next  = job_pop ? 1'b1 : ((emit && final_item) ? 1'b0 : busy_reg);
        valid_next = emit ? 1'b1 : (out_ch.ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign out_ch.valid    = valid_reg;
    assign out_ch.out_byte = byte_reg;
    assign out_ch.out_last = last_reg;
    assign out_ch.error    = err_reg;

    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (last_reg && byte_reg == 8'h00))
        else $error("error item without last or with nonzero byte");

    a_dec_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cur_reg.kind == JOB_DEC) |-> (idx_reg != 2'd3))
        else $error("decode job ran past its third byte");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cur_reg.kind == JOB_ERR) |-> (idx_reg == 2'd0))
        else $error("error job gave more than one item");

    a_pop_final: assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop && busy_reg) |=> (valid_reg && (last_reg == $past(cur_reg.last))))
        else $error("next job taken before the current one finished");

endmodule

FILE: sv/sixbit_text_codec.sv
// Six-bit text codec top level: front end, job queue and back end.
// Each result item passes through the job queue, the back end's job register and its output register.
// Throughput: decode takes one input item per cycle while the queue has room; encode gives four result items
//   per three bytes, limited by the single result register in the back end.
// Reset: rst_n clears mode to encode, the partial group, the queue and the output.
// Writing mode also clears any partial group so no message spans a mode change.
module sixbit_text_codec #(
    parameter int unsigned QUEUE_DEPTH = stc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    stc_in_if.sink    in_ch,
    stc_out_if.source out_ch,
    stc_cfg_if.sink   cfg
);
    import stc_pkg::*;

    // Front to queue: one job per completed group, per short encode group at a message end, or per failing message end.
    logic push_valid;
    job_t push_job;
    logic push_ready;

    // Queue to back end.
    logic pop_valid;
    job_t pop_job;
    logic pop_ready;

    stc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .job_valid (push_valid),
        .job       (push_job),
        .job_ready (push_ready)
    );

    // The queue lets the front keep taking items while the back drains a group.
    stc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    stc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop_ready),
        .out_ch    (out_ch)
    );

endmodule
